// ----- hdl/ssl_pkg.sv -----
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and constants for the streaming substring locator.
// ----------------------------------------------------------------------------
package ssl_pkg;

  // Sizes
  localparam int PATTERN_MAX_DEF = 8;
  localparam int BYTE_W          = 8;
  localparam int LINE_W          = 24;
  localparam int COL_W           = 16;
  localparam int PAT_W           = 64;
  localparam int LEN_W           = 4;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 2;

  // Saturation limits and special bytes
  localparam logic [LINE_W-1:0] LINE_MAX     = '1;
  localparam logic [COL_W-1:0]  COL_MAX      = '1;
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1
  } cfg_idx_t;

  // Request payload
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              file_start;
  } in_t;

  // Result payload
  typedef struct packed {
    logic [LINE_W-1:0] match_line;
    logic [COL_W-1:0]  match_column;
  } out_t;

  // Match status from the window to the top level
  typedef struct packed {
    logic              hit;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
  } match_t;

endpackage

// ----- hdl/ssl_window.sv -----
// ----------------------------------------------------------------------------
// ssl_window
// Sliding window of the last bytes with their line/column tags, the line and
// column counters, and the combinational pattern compare.
// ----------------------------------------------------------------------------
module ssl_window #(
  parameter int PATTERN_MAX = ssl_pkg::PATTERN_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  ssl_pkg::in_t                in_item,
  input  logic [ssl_pkg::PAT_W-1:0]   pat_bytes,
  input  logic [ssl_pkg::LEN_W-1:0]   pat_len,
  output ssl_pkg::match_t             match
);

  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam logic [ssl_pkg::LEN_W-1:0] LEN_CAP = ssl_pkg::LEN_W'(PATTERN_MAX);
  localparam logic [FILL_W-1:0]         FILL_CAP = FILL_W'(PATTERN_MAX);

  // Window storage, index 0 holds the newest byte
  logic [ssl_pkg::BYTE_W-1:0] text_r   [PATTERN_MAX];
  logic [ssl_pkg::LINE_W-1:0] line_r   [PATTERN_MAX];
  logic [ssl_pkg::COL_W-1:0]  col_r    [PATTERN_MAX];
  logic [ssl_pkg::BYTE_W-1:0] text_nxt [PATTERN_MAX];
  logic [ssl_pkg::LINE_W-1:0] line_nxt [PATTERN_MAX];
  logic [ssl_pkg::COL_W-1:0]  col_nxt  [PATTERN_MAX];

  logic [FILL_W-1:0]          fill_r, fill_nxt, fill_base;
  logic [ssl_pkg::LINE_W-1:0] line_cnt_r, line_cnt_nxt, line_base;
  logic [ssl_pkg::COL_W-1:0]  col_cnt_r, col_cnt_nxt, col_base, col_cur;

  logic [ssl_pkg::LEN_W-1:0]  len_eff;
  logic [IDX_W-1:0]           first_idx;
  logic                       bytes_eq;

  // Next window and counters; a file start empties the window first
  always_comb begin
    fill_base = in_item.file_start ? '0 : fill_r;
    line_base = in_item.file_start ? ssl_pkg::LINE_W'(1) : line_cnt_r;
    col_base  = in_item.file_start ? '0 : col_cnt_r;
    col_cur   = (col_base < ssl_pkg::COL_MAX) ? col_base + 1'b1 : ssl_pkg::COL_MAX;

    text_nxt[0] = in_item.text_byte;
    line_nxt[0] = line_base;
    col_nxt[0]  = col_cur;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      text_nxt[k] = text_r[k-1];
      line_nxt[k] = line_r[k-1];
      col_nxt[k]  = col_r[k-1];
    end

    fill_nxt = (fill_base < FILL_CAP) ? fill_base + 1'b1 : fill_base;

    if (in_item.text_byte == ssl_pkg::NEWLINE_BYTE) begin
      line_cnt_nxt = (line_base < ssl_pkg::LINE_MAX) ? line_base + 1'b1 : line_base;
      col_cnt_nxt  = '0;
    end else begin
      line_cnt_nxt = line_base;
      col_cnt_nxt  = col_cur;
    end
  end

  // Pattern compare: pattern byte i against window entry len-1-i
  always_comb begin
    logic [ssl_pkg::LEN_W-1:0] pos;
    len_eff  = (pat_len > LEN_CAP) ? LEN_CAP : pat_len;
    bytes_eq = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pos = len_eff - 1'b1 - ssl_pkg::LEN_W'(i);
      if (ssl_pkg::LEN_W'(i) < len_eff &&
          text_nxt[pos[IDX_W-1:0]] != pat_bytes[8*i +: 8]) begin
        bytes_eq = 1'b0;
      end
    end
    first_idx    = IDX_W'(len_eff - 1'b1);
    match.hit    = bytes_eq && (len_eff != '0) &&
                   (len_eff <= ssl_pkg::LEN_W'(fill_nxt));
    match.line   = line_nxt[first_idx];
    match.column = col_nxt[first_idx];
  end

  // Window shift, only read below the fill count so no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        text_r[k] <= text_nxt[k];
        line_r[k] <= line_nxt[k];
        col_r[k]  <= col_nxt[k];
      end
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      line_cnt_r <= ssl_pkg::LINE_W'(1);
      col_cnt_r  <= '0;
    end else if (take) begin
      fill_r     <= fill_nxt;
      line_cnt_r <= line_cnt_nxt;
      col_cnt_r  <= col_cnt_nxt;
    end
  end

endmodule

// ----- hdl/streaming_substring_locator.sv -----
// ----------------------------------------------------------------------------
// streaming_substring_locator
// Finds every occurrence of a 1..8 byte pattern in a byte stream and reports
// the line and column of each match's first byte.
// ----------------------------------------------------------------------------
// Takes one text byte per clock when the result side is not stalled. The
// window shift, the counter update and the pattern compare sit between the
// input handshake and the output register, so a match appears on out_valid
// the cycle after its last byte is accepted. Overlapping matches are all
// reported. Lines and columns count from 1 and saturate at their field
// maximum; a newline ends its own line. file_start on a byte empties the
// window and restarts the counters before that byte is taken in. Write
// configuration only while idle.
module streaming_substring_locator #(
  parameter int PATTERN_MAX = ssl_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssl_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssl_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [ssl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ssl_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [ssl_pkg::PAT_W-1:0] pattern_r;
  logic [ssl_pkg::LEN_W-1:0] length_r;
  logic                      out_vld_r, out_vld_nxt;
  ssl_pkg::out_t             out_data_r;
  ssl_pkg::match_t           match;
  logic                      take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= ssl_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ssl_pkg::CFG_PATTERN_BYTES:  pattern_r <= cfg_wdata[ssl_pkg::PAT_W-1:0];
        ssl_pkg::CFG_PATTERN_LENGTH: length_r  <= cfg_wdata[ssl_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: accept whenever the output register is free or draining
  assign in_ready = !out_vld_r || out_ready;
  assign take     = in_valid && in_ready;

  ssl_window #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_item   (in_data),
    .pat_bytes (pattern_r),
    .pat_len   (length_r),
    .match     (match)
  );

  // Result register
  always_comb begin
    if (take)           out_vld_nxt = match.hit;
    else if (out_ready) out_vld_nxt = 1'b0;
    else                out_vld_nxt = out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && match.hit) begin
      out_data_r.match_line   <= match.line;
      out_data_r.match_column <= match.column;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Checks
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r.match_line != '0) && (out_data_r.match_column != '0))
    else $error("match reported at line or column zero");

  a_empty_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (take && length_r == '0) |=> !out_vld_r)
    else $error("empty pattern produced a match");

  a_file_start: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_data.file_start && length_r > ssl_pkg::LEN_W'(1)) |=> !out_vld_r)
    else $error("match straddled a file start");

endmodule
